// ===== design/exact_match_route_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// exact_match_route_table_top_macros
// Assertion macros for the route table. Each one expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef EXACT_MATCH_ROUTE_TABLE_TOP_MACROS_SVH
`define EXACT_MATCH_ROUTE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define EMRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("route table check failed");

// next-cycle implication
`define EMRT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("route table check failed");

`endif

// ===== design/emrt_pkg.sv =====
// ----------------------------------------------------------------------------
// emrt_pkg
// Types and constants shared by the exact-match route table modules.
// ----------------------------------------------------------------------------
package emrt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W       = 5;
	localparam int USE_W       = 6;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_UPDATE = 2'd1,
		OP_DELETE = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_PRESENT = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [5:0]  prefix;
		logic [31:0] gateway;
		logic [47:0] hw_addr;
		logic [7:0]  iface;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  entry_position;
		logic [5:0]  entries_in_use;
		logic [31:0] found_gateway;
		logic [47:0] found_mac;
		logic [7:0]  found_interface;
	} result_t;

	typedef struct packed {
		logic    start;
		logic    scan;
		logic    append;
		logic    rewrite;
		logic    shift;
		logic    dec;
		logic    load_result;
		status_t res_status;
		logic    res_data;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic hit;
		logic miss;
		logic shift_done;
	} dp_stat_t;

endpackage

// ===== design/emrt_if.sv =====
// ----------------------------------------------------------------------------
// emrt_if
// Request and response channels of the route table (valid/ready).
// ----------------------------------------------------------------------------
interface emrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] dest_address;
	logic [5:0]  prefix_length;
	logic [31:0] gateway_address;
	logic [47:0] mac_address;
	logic [7:0]  out_interface;

	modport source (output valid, operation, dest_address, prefix_length,
		gateway_address, mac_address, out_interface, input ready);
	modport sink (input valid, operation, dest_address, prefix_length,
		gateway_address, mac_address, out_interface, output ready);
endinterface

interface emrt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  entry_position;
	logic [5:0]  entries_in_use;
	logic [31:0] found_gateway;
	logic [47:0] found_mac;
	logic [7:0]  found_interface;

	modport source (output valid, status, entry_position, entries_in_use,
		found_gateway, found_mac, found_interface, input ready);
	modport sink (input valid, status, entry_position, entries_in_use,
		found_gateway, found_mac, found_interface, output ready);
endinterface

// ===== design/exact_match_route_table_top.sv =====
// ----------------------------------------------------------------------------
// exact_match_route_table_top
// Exact-match route table with linear search and packed storage.
// ----------------------------------------------------------------------------
// One request is worked at a time. A lookup or a create that finds its key
// answers once the scan reaches it, an update after a further commit step, and a
// miss once the scan has passed every entry in use; a create that appends adds a
// commit step to its miss. A delete adds a shift that moves the later entries
// down. A create on a full table answers without a scan. The entry memory gives
// one registered read per cycle to the scan and to the shift. The result sits in
// an output register, and the block is ready for the next request in the same
// cycle that the result turns valid, while the result waits.
module exact_match_route_table_top
	import emrt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	emrt_req_if.sink        req,
	emrt_rsp_if.source      rsp
);

`include "exact_match_route_table_top_macros.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;
	entry_t   req_entry;
	result_t  result;

	assign req_entry.dest    = req.dest_address;
	assign req_entry.prefix  = req.prefix_length;
	assign req_entry.gateway = req.gateway_address;
	assign req_entry.hw_addr = req.mac_address;
	assign req_entry.iface   = req.out_interface;

	emrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (op_t'(req.operation)),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	emrt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_entry (req_entry),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	assign rsp.status          = result.status;
	assign rsp.entry_position  = result.entry_position;
	assign rsp.entries_in_use  = result.entries_in_use;
	assign rsp.found_gateway   = result.found_gateway;
	assign rsp.found_mac       = result.found_mac;
	assign rsp.found_interface = result.found_interface;

	`EMRT_ASSERT_NXT(a_one_request, req.valid && req.ready, !req.ready)
	`EMRT_ASSERT_IMP(a_hit_xor_miss, stat.hit, !stat.miss)
	`EMRT_ASSERT_IMP(a_load_free, cmd.load_result, !rsp.valid || rsp.ready)
	`EMRT_ASSERT_IMP(a_err_no_data, rsp.valid && (rsp.status != ST_OK),
		(rsp.entry_position == '0) && (rsp.found_gateway == '0)
		&& (rsp.found_mac == '0) && (rsp.found_interface == '0))

endmodule

// ===== design/emrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// emrt_ctrl
// Sequencer: accepts a request, runs search, commit and shift, loads the result.
// ----------------------------------------------------------------------------
module emrt_ctrl
	import emrt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  op_t      in_op,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_COMMIT = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t  state_q, state_d;
	op_t     op_q, op_d;
	status_t st_q, st_d;
	logic    data_q, data_d;
	logic    out_valid_q;
	logic    load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		st_d    = st_q;
		data_d  = data_q;
		cmd     = '0;
		cmd.res_status  = st_q;
		cmd.res_data    = data_q;
		cmd.load_result = load;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					op_d      = in_op;
					if (in_op == OP_CREATE && stat.full) begin
						st_d    = ST_FULL;
						data_d  = 1'b0;
						state_d = S_RESULT;
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					st_d   = ST_OK;
					data_d = 1'b1;
					case (op_q)
						OP_CREATE: begin
							st_d    = ST_PRESENT;
							data_d  = 1'b0;
							state_d = S_RESULT;
						end
						OP_UPDATE: state_d = S_COMMIT;
						OP_DELETE: state_d = S_SHIFT;
						default:   state_d = S_RESULT;
					endcase
				end else if (stat.miss) begin
					if (op_q == OP_CREATE) begin
						state_d = S_COMMIT;
					end else begin
						st_d    = ST_MISSING;
						data_d  = 1'b0;
						state_d = S_RESULT;
					end
				end
			end
			S_COMMIT: begin
				if (op_q == OP_CREATE) begin
					cmd.append = 1'b1;
				end else begin
					cmd.rewrite = 1'b1;
				end
				st_d    = ST_OK;
				data_d  = 1'b1;
				state_d = S_RESULT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.shift_done) begin
					cmd.dec = 1'b1;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_CREATE;
			st_q        <= ST_OK;
			data_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			st_q    <= st_d;
			data_q  <= data_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/emrt_dp.sv =====
// ----------------------------------------------------------------------------
// emrt_dp
// Entry memory, entry count, pipelined scan/compare, shift-down and result reg.
// ----------------------------------------------------------------------------
module emrt_dp
	import emrt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  entry_t   req_entry,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output result_t  result
);

	entry_t             mem_q [TABLE_DEPTH];
	entry_t             rd_data_q;
	entry_t             req_q;
	entry_t             hit_entry_q;
	entry_t             wr_data;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               cmp_vld_s1;
	logic [CNT_W-1:0]   scan_idx_q;
	logic [CNT_W-1:0]   count_q;
	logic               wr_en;
	logic               issue;
	logic               match;
	logic               walking;
	logic [31:0]        pos_ext;
	logic [31:0]        cnt_ext;
	result_t            res_q;

	assign walking = cmd.scan || cmd.shift;
	assign issue   = walking && (scan_idx_q < count_q);
	assign rd_addr = scan_idx_q[IDX_W-1:0];
	assign match   = cmp_vld_s1 && (rd_data_q.dest == req_q.dest)
		&& (rd_data_q.prefix == req_q.prefix);

	assign stat.full       = (count_q == CNT_W'(TABLE_DEPTH));
	assign stat.hit        = cmd.scan && match;
	assign stat.miss       = cmd.scan && !cmp_vld_s1 && (scan_idx_q >= count_q);
	assign stat.shift_done = cmd.shift && !cmp_vld_s1 && (scan_idx_q >= count_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmp_idx_s1 - IDX_W'(1);
		wr_data = rd_data_q;
		if (cmd.append) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IDX_W-1:0];
			wr_data = req_q;
		end else if (cmd.rewrite) begin
			wr_en           = 1'b1;
			wr_addr         = hit_idx_q;
			wr_data         = hit_entry_q;
			wr_data.gateway = req_q.gateway;
			wr_data.iface   = req_q.iface;
		end else if (cmd.shift && cmp_vld_s1) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// start only comes while idle, when no read is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue && !(cmd.scan && match);
			if (cmd.start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan && match) begin
				scan_idx_q <= CNT_W'(cmp_idx_s1) + CNT_W'(1);
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_addr;
		if (cmd.start) begin
			req_q <= req_entry;
		end
		if (cmd.scan && match) begin
			hit_idx_q   <= cmp_idx_s1;
			hit_entry_q <= rd_data_q;
		end else if (cmd.append) begin
			hit_idx_q   <= count_q[IDX_W-1:0];
			hit_entry_q <= req_q;
		end else if (cmd.rewrite) begin
			hit_entry_q.gateway <= req_q.gateway;
			hit_entry_q.iface   <= req_q.iface;
		end
	end

	assign pos_ext = 32'(hit_idx_q);
	assign cnt_ext = 32'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_q.status         <= cmd.res_status;
			res_q.entries_in_use <= cnt_ext[USE_W-1:0];
			if (cmd.res_data) begin
				res_q.entry_position  <= pos_ext[POS_W-1:0];
				res_q.found_gateway   <= hit_entry_q.gateway;
				res_q.found_mac       <= hit_entry_q.hw_addr;
				res_q.found_interface <= hit_entry_q.iface;
			end else begin
				res_q.entry_position  <= '0;
				res_q.found_gateway   <= '0;
				res_q.found_mac       <= '0;
				res_q.found_interface <= '0;
			end
		end
	end

	assign result = res_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the exact-match route table. A shadow copy of the
// table predicts status, position, count and entry data for every accepted
// request; responses are compared in order. Directed requests hit the empty,
// duplicate, near-miss and wide-prefix cases, then random create/update/
// delete/lookup phases grow the table to full, churn it and shrink it, with
// random idle gaps on both channels and long response hold-offs.
// ----------------------------------------------------------------------------
module testbench;
	import emrt_pkg::*;

	localparam int KEY_POOL   = 48;
	localparam int RAND_COUNT = 450;
	localparam int PHASE_LEN  = 75;

	class route_table_shadow;
		logic [31:0] dest_tbl   [TABLE_DEPTH];
		logic [5:0]  prefix_tbl [TABLE_DEPTH];
		logic [31:0] gw_tbl     [TABLE_DEPTH];
		logic [47:0] mac_tbl    [TABLE_DEPTH];
		logic [7:0]  iface_tbl  [TABLE_DEPTH];
		int          used;
		result_t     pending_results [$];
		int          errors;

		function new();
			used   = 0;
			errors = 0;
		endfunction

		function int find_key(logic [31:0] dest, logic [5:0] prefix);
			for (int i = 0; i < used; i++) begin
				if (dest_tbl[i] == dest && prefix_tbl[i] == prefix)
					return i;
			end
			return -1;
		endfunction

		function result_t entry_result(status_t st, int pos);
			result_t r;
			r.status          = st;
			r.entry_position  = pos[4:0];
			r.entries_in_use  = used[5:0];
			r.found_gateway   = gw_tbl[pos];
			r.found_mac       = mac_tbl[pos];
			r.found_interface = iface_tbl[pos];
			return r;
		endfunction

		function result_t fault_result(status_t st);
			result_t r;
			r                = '0;
			r.status         = st;
			r.entries_in_use = used[5:0];
			return r;
		endfunction

		function void note_request(op_t op, logic [31:0] dest, logic [5:0] prefix,
			logic [31:0] gw, logic [47:0] mac, logic [7:0] iface);
			int      hit;
			result_t r;
			hit = find_key(dest, prefix);
			if (op == OP_CREATE) begin
				if (used >= TABLE_DEPTH) begin
					r = fault_result(ST_FULL);
				end else if (hit >= 0) begin
					r = fault_result(ST_PRESENT);
				end else begin
					dest_tbl[used]   = dest;
					prefix_tbl[used] = prefix;
					gw_tbl[used]     = gw;
					mac_tbl[used]    = mac;
					iface_tbl[used]  = iface;
					used++;
					r = entry_result(ST_OK, used - 1);
				end
			end else if (hit < 0) begin
				r = fault_result(ST_MISSING);
			end else begin
				case (op)
					OP_UPDATE: begin
						gw_tbl[hit]    = gw;
						iface_tbl[hit] = iface;
						r = entry_result(ST_OK, hit);
					end
					OP_DELETE: begin
						r = entry_result(ST_OK, hit);
						for (int i = hit + 1; i < used; i++) begin
							dest_tbl[i - 1]   = dest_tbl[i];
							prefix_tbl[i - 1] = prefix_tbl[i];
							gw_tbl[i - 1]     = gw_tbl[i];
							mac_tbl[i - 1]    = mac_tbl[i];
							iface_tbl[i - 1]  = iface_tbl[i];
						end
						used--;
						r.entries_in_use = used[5:0];
					end
					default: begin
						r = entry_result(ST_OK, hit);
					end
				endcase
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected response st=%0d pos=%0d use=%0d", $realtime,
						got.status, got.entry_position, got.entries_in_use);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.entry_position !== want.entry_position ||
				got.entries_in_use !== want.entries_in_use ||
				got.found_gateway !== want.found_gateway || got.found_mac !== want.found_mac ||
				got.found_interface !== want.found_interface) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp st=%0d pos=%0d use=%0d gw=%h mac=%h if=%h",
						$realtime,
						want.status, want.entry_position, want.entries_in_use,
						want.found_gateway, want.found_mac, want.found_interface,
						" | got st=%0d pos=%0d use=%0d gw=%h mac=%h if=%h",
						got.status, got.entry_position, got.entries_in_use,
						got.found_gateway, got.found_mac, got.found_interface);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	emrt_req_if req_ch ();
	emrt_rsp_if rsp_ch ();

	route_table_shadow shadow = new();

	logic [31:0] key_dest   [KEY_POOL];
	logic [5:0]  key_prefix [KEY_POOL];
	int          send_calm;
	int          drain_calm;

	exact_match_route_table_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] rand_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		int          r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	// phase 0 grows the table, 1 churns it, 2 drains it
	function automatic op_t pick_op(int phase);
		int r;
		r = $urandom_range(0, 99);
		case (phase)
			0: begin
				if (r < 80) return OP_CREATE;
				if (r < 85) return OP_UPDATE;
				if (r < 90) return OP_DELETE;
				return OP_LOOKUP;
			end
			1: begin
				if (r < 25) return OP_CREATE;
				if (r < 50) return OP_UPDATE;
				if (r < 75) return OP_DELETE;
				return OP_LOOKUP;
			end
			default: begin
				if (r < 15) return OP_CREATE;
				if (r < 25) return OP_UPDATE;
				if (r < 80) return OP_DELETE;
				return OP_LOOKUP;
			end
		endcase
	endfunction

	function automatic void pick_key(op_t op, output logic [31:0] dest,
		output logic [5:0] prefix);
		int k;
		if (op != OP_CREATE && shadow.used > 0 && $urandom_range(0, 99) < 75) begin
			k      = $urandom_range(0, shadow.used - 1);
			dest   = shadow.dest_tbl[k];
			prefix = shadow.prefix_tbl[k];
		end else if ($urandom_range(0, 99) < ((op == OP_CREATE) ? 25 : 10)) begin
			dest   = rand_word();
			prefix = 6'($urandom_range(0, 63));
		end else begin
			k      = $urandom_range(0, KEY_POOL - 1);
			dest   = key_dest[k];
			prefix = key_prefix[k];
		end
	endfunction

	task automatic send_request(input op_t op, input logic [31:0] dest,
		input logic [5:0] prefix, input logic [31:0] gw, input logic [47:0] mac,
		input logic [7:0] iface);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.operation       <= op;
		req_ch.dest_address    <= dest;
		req_ch.prefix_length   <= prefix;
		req_ch.gateway_address <= gw;
		req_ch.mac_address     <= mac;
		req_ch.out_interface   <= iface;
		do @(posedge clk); while (!req_ch.ready);
		shadow.note_request(op, dest, prefix, gw, mac, iface);
	endtask

	// response side; two long hold-offs let the block back up into the request side
	initial begin : drain
		int      stall;
		int      seen;
		result_t got;
		seen       = 0;
		drain_calm = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (seen == 150 || seen == 330)
				stall = 300;
			else
				stall = pick_gap(drain_calm);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got.status          = status_t'(rsp_ch.status);
			got.entry_position  = rsp_ch.entry_position;
			got.entries_in_use  = rsp_ch.entries_in_use;
			got.found_gateway   = rsp_ch.found_gateway;
			got.found_mac       = rsp_ch.found_mac;
			got.found_interface = rsp_ch.found_interface;
			shadow.check_result(got);
			seen++;
		end
	end

	initial begin : stimulus
		op_t         op;
		logic [31:0] dest;
		logic [5:0]  prefix;
		send_calm = 0;
		req_ch.valid           <= 1'b0;
		req_ch.operation       <= OP_CREATE;
		req_ch.dest_address    <= '0;
		req_ch.prefix_length   <= '0;
		req_ch.gateway_address <= '0;
		req_ch.mac_address     <= '0;
		req_ch.out_interface   <= '0;
		for (int i = 0; i < KEY_POOL; i++) begin
			key_dest[i]   = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
			key_prefix[i] = (i % 8 == 7) ? 6'($urandom_range(33, 63))
				: 6'($urandom_range(0, 32));
		end
		wait (arst_n === 1'b1);
		@(posedge clk);

		// empty table: everything but create misses
		send_request(OP_LOOKUP, 32'h0, 6'd0, '0, '0, '0);
		send_request(OP_UPDATE, 32'h0, 6'd0, '1, '1, '1);
		send_request(OP_DELETE, 32'hFFFF_FFFF, 6'd63, '0, '0, '0);
		// field extremes, prefix above 32, same address with different prefixes
		send_request(OP_CREATE, 32'h0, 6'd0, 32'h0, 48'h0, 8'h00);
		send_request(OP_CREATE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, '1, 8'hFF);
		send_request(OP_CREATE, 32'hFFFF_FFFF, 6'd32, 32'h1234_5678, 48'hA5A5_5A5A_0F0F,
			8'h05);
		send_request(OP_CREATE, 32'h0A00_0000, 6'd8, 32'hC0A8_0001, 48'h0, 8'h01);
		// duplicate create fails
		send_request(OP_CREATE, 32'hFFFF_FFFF, 6'd63, 32'h0, 48'h0, 8'h00);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, '1, '1, '1);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd31, '0, '0, '0);
		send_request(OP_LOOKUP, 32'h7FFF_FFFF, 6'd63, '0, '0, '0);
		// update keeps the stored hardware address
		send_request(OP_UPDATE, 32'hFFFF_FFFF, 6'd32, 32'h8765_4321, 48'h1111_2222_3333,
			8'hFE);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd32, '0, '0, '0);
		// delete the first entry, later entries move down
		send_request(OP_DELETE, 32'h0, 6'd0, '1, '1, '1);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, '0, '0, '0);
		send_request(OP_LOOKUP, 32'h0A00_0000, 6'd8, '0, '0, '0);
		// delete the last entry, then the same again misses
		send_request(OP_DELETE, 32'h0A00_0000, 6'd8, '0, '0, '0);
		send_request(OP_DELETE, 32'h0A00_0000, 6'd8, '0, '0, '0);
		send_request(OP_CREATE, 32'h0, 6'd0, 32'h0000_0001, 48'h0000_0000_0001, 8'h80);

		for (int n = 0; n < RAND_COUNT; n++) begin
			op = pick_op((n / PHASE_LEN) % 3);
			pick_key(op, dest, prefix);
			send_request(op, dest, prefix, rand_word(), rand_mac(), 8'($urandom));
		end
		req_ch.valid <= 1'b0;

		while (shadow.pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (shadow.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
